// ----- hw/rtl/rtnf_pkg.sv -----
`default_nettype none

package rtnf_pkg;

    // Field widths
    localparam int ADDR_W  = 48;
    localparam int LEVEL_W = 8;
    localparam int TIME_W  = 32;
    localparam int HASH_W  = 32;

    // Parameter defaults
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int TOP_N_DEF       = 16;

    // Width used when comparing entry counts against TOP_N
    localparam int CMP_W = 8;

    // djb2 seed, empty level, bytes per address
    localparam logic [HASH_W-1:0]         HASH_SEED  = 32'd5381;
    localparam logic signed [LEVEL_W-1:0] NO_LEVEL   = -8'sd128;
    localparam int                        ADDR_BYTES = 6;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One scan entry as it travels from the front to the back
    typedef struct packed {
        logic [ADDR_W-1:0]         station_address;
        logic signed [LEVEL_W-1:0] signal_level;
        logic [TIME_W-1:0]         scan_time;
        logic                      last_item;
    } cmd_t;

    // One djb2 round: h*33 + byte, wrapping at 32 bits
    function automatic logic [HASH_W-1:0] djb2_step(input logic [HASH_W-1:0] h,
                                                     input logic [7:0] b);
        djb2_step = (h << 5) + h + {{(HASH_W-8){1'b0}}, b};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rtnf_ram.sv -----
`default_nettype none

module rtnf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rtnf_front.sv -----
`default_nettype none

module rtnf_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rtnf_pkg::ADDR_W-1:0]    station_address,
    input  wire logic signed [rtnf_pkg::LEVEL_W-1:0] signal_level,
    input  wire logic [rtnf_pkg::TIME_W-1:0]    scan_time,
    input  wire logic                           last_item,
    output logic                                cmd_valid,
    output rtnf_pkg::cmd_t                      cmd,
    input  wire logic                           cmd_pop
);

    import rtnf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;
    cmd_t             incoming;

    // Gather the transaction into one command
    always_comb
    begin
        incoming.station_address = station_address;
        incoming.signal_level    = signal_level;
        incoming.scan_time       = scan_time;
        incoming.last_item       = last_item;
    end

    assign busy      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = start && !busy;
    assign pop       = cmd_pop && cmd_valid;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rtnf_back.sv -----
`default_nettype none

module rtnf_back #(
    parameter int  MAX_ENTRIES = rtnf_pkg::MAX_ENTRIES_DEF,
    parameter int  TOP_N       = rtnf_pkg::TOP_N_DEF,
    localparam int SLOT_W      = (TOP_N > 1) ? $clog2(TOP_N) : 1,
    localparam int CNT_W       = $clog2(TOP_N + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cmd_valid,
    input  wire rtnf_pkg::cmd_t                      cmd,
    output logic                                     cmd_pop,
    output logic                                     strobe,
    output logic [SLOT_W-1:0]                        slot_index,
    output logic [rtnf_pkg::HASH_W-1:0]              address_hash,
    output logic signed [rtnf_pkg::LEVEL_W-1:0]      slot_level,
    output logic [CNT_W-1:0]                         entry_count,
    output logic [rtnf_pkg::TIME_W-1:0]              stamp,
    output logic                                     final_slot
);

    import rtnf_pkg::*;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LOAD_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W  = ADDR_W + LEVEL_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SLOT = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_HASH = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [LOAD_W-1:0]         loaded_reg, loaded_next;
    logic [CNT_W-1:0]          top_reg, top_next;
    logic [TIME_W-1:0]         time_reg, time_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [MAX_ENTRIES-1:0]    chosen_reg, chosen_next;
    logic [LOAD_W-1:0]         scan_reg, scan_next;
    logic                      pend_reg, pend_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic signed [LEVEL_W-1:0] best_level_reg, best_level_next;
    logic [ADDR_W-1:0]         best_addr_reg, best_addr_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic                      found_reg, found_next;
    logic [HASH_W-1:0]         hash_reg, hash_next;
    logic [2:0]                byte_reg, byte_next;

    logic                      strobe_reg, strobe_next;
    logic [SLOT_W-1:0]         out_slot_reg, out_slot_next;
    logic [HASH_W-1:0]         out_hash_reg, out_hash_next;
    logic signed [LEVEL_W-1:0] out_level_reg, out_level_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;
    logic [TIME_W-1:0]         out_stamp_reg, out_stamp_next;
    logic                      out_final_reg, out_final_next;

    logic                      ram_we;
    logic [ENT_W-1:0]          ram_wdata;
    logic [ENT_W-1:0]          ram_rdata;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [LEVEL_W-1:0] rd_level;
    logic                      has_room;
    logic [LOAD_W-1:0]         loaded_after;
    logic [CMP_W-1:0]          loaded_wide;
    logic                      issue;
    logic                      last_slot;

    // Entry store: address and level side by side
    rtnf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (loaded_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_wdata    = {cmd.station_address, cmd.signal_level};
    assign rd_addr      = ram_rdata[ENT_W-1:LEVEL_W];
    assign rd_level     = $signed(ram_rdata[LEVEL_W-1:0]);
    assign has_room     = (loaded_reg < LOAD_W'(MAX_ENTRIES));
    assign loaded_after = has_room ? loaded_reg + 1'b1 : loaded_reg;
    assign loaded_wide  = CMP_W'(loaded_after);
    assign cmd_pop      = (state_reg == ST_IDLE);
    assign ram_we       = cmd_pop && cmd_valid && has_room;
    assign issue        = (scan_reg < loaded_reg);
    assign last_slot    = (slot_reg == SLOT_W'(TOP_N - 1));

    // Sequencer: store entries, then rank and emit on the closing entry
    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        top_next        = top_reg;
        time_next       = time_reg;
        slot_next       = slot_reg;
        chosen_next     = chosen_reg;
        scan_next       = scan_reg;
        pend_next       = 1'b0;
        idx_next        = idx_reg;
        best_level_next = best_level_reg;
        best_addr_next  = best_addr_reg;
        best_idx_next   = best_idx_reg;
        found_next      = found_reg;
        hash_next       = hash_reg;
        byte_next       = byte_reg;
        strobe_next     = 1'b0;
        out_slot_next   = out_slot_reg;
        out_hash_next   = out_hash_reg;
        out_level_next  = out_level_reg;
        out_count_next  = out_count_reg;
        out_stamp_next  = out_stamp_reg;
        out_final_next  = out_final_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    loaded_next = loaded_after;
                    if (cmd.last_item)
                    begin
                        time_next  = cmd.scan_time;
                        top_next   = (loaded_wide < CMP_W'(TOP_N)) ?
                                     CNT_W'(loaded_wide) : CNT_W'(TOP_N);
                        slot_next  = '0;
                        state_next = ST_SLOT;
                    end
                end
            end

            ST_SLOT:
            begin
                found_next      = 1'b0;
                best_level_next = NO_LEVEL;
                scan_next       = '0;
                if (CNT_W'(slot_reg) < top_reg)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_SCAN:
            begin
                // Read one entry a cycle, compare the one that arrived
                if (issue)
                begin
                    pend_next = 1'b1;
                    idx_next  = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                if (pend_reg && !chosen_reg[idx_reg] && (rd_level > best_level_reg))
                begin
                    best_level_next = rd_level;
                    best_addr_next  = rd_addr;
                    best_idx_next   = idx_reg;
                    found_next      = 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    if (found_reg)
                    begin
                        chosen_next[best_idx_reg] = 1'b1;
                        hash_next  = HASH_SEED;
                        byte_next  = '0;
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_HASH:
            begin
                // One address byte per cycle, first byte first
                hash_next      = djb2_step(hash_reg, best_addr_reg[ADDR_W-1 -: 8]);
                best_addr_next = best_addr_reg << 8;
                byte_next      = byte_reg + 1'b1;
                if (byte_reg == 3'(ADDR_BYTES - 1))
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                strobe_next    = 1'b1;
                out_slot_next  = slot_reg;
                out_hash_next  = found_reg ? hash_reg : '0;
                out_level_next = found_reg ? best_level_reg : NO_LEVEL;
                out_count_next = top_reg;
                out_stamp_next = time_reg;
                out_final_next = last_slot;
                if (last_slot)
                begin
                    chosen_next = '0;
                    loaded_next = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_SLOT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            loaded_reg <= '0;
            time_reg   <= '0;
            chosen_reg <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            time_reg   <= time_next;
            chosen_reg <= chosen_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        slot_reg       <= slot_next;
        scan_reg       <= scan_next;
        idx_reg        <= idx_next;
        best_level_reg <= best_level_next;
        best_addr_reg  <= best_addr_next;
        best_idx_reg   <= best_idx_next;
        found_reg      <= found_next;
        hash_reg       <= hash_next;
        byte_reg       <= byte_next;
        out_slot_reg   <= out_slot_next;
        out_hash_reg   <= out_hash_next;
        out_level_reg  <= out_level_next;
        out_count_reg  <= out_count_next;
        out_stamp_reg  <= out_stamp_next;
        out_final_reg  <= out_final_next;
    end

    assign strobe       = strobe_reg;
    assign slot_index   = out_slot_reg;
    assign address_hash = out_hash_reg;
    assign slot_level   = out_level_reg;
    assign entry_count  = out_count_reg;
    assign stamp        = out_stamp_reg;
    assign final_slot   = out_final_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/rssi_top_n_fingerprint.sv -----
`default_nettype none

// Ranks one scan of access-point entries by signal level. Each start
// transaction carries one entry; up to MAX_ENTRIES are kept and later ones
// are dropped. The entry flagged last_item closes the scan and then
// TOP_N slots come out strongest first, one per cycle in which strobe
// is high, with slot_index counting up and final_slot on the last. The
// receiver cannot stall: strobe marks each slot for one cycle only. A
// chosen slot carries the djb2 hash of its address; an empty slot carries
// hash 0 and level -128. Entries go through a two-deep command queue, so
// start is taken whenever busy is low. The ranking engine takes stored
// entries only while it is idle. Closing a scan of L stored entries takes,
// per slot that holds an entry, slot set-up, one read of the entry store
// per entry, read latency, scan wind-up, six hash rounds and one emit step.
// A slot within entry_count for which no valid entry is left skips the hash
// rounds, and a slot at or beyond entry_count goes straight from set-up to
// emit; busy stays high while the queue is full behind that work.
module rssi_top_n_fingerprint #(
    parameter int  MAX_ENTRIES = rtnf_pkg::MAX_ENTRIES_DEF,
    parameter int  TOP_N       = rtnf_pkg::TOP_N_DEF,
    localparam int SLOT_W      = (TOP_N > 1) ? $clog2(TOP_N) : 1,
    localparam int CNT_W       = $clog2(TOP_N + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [rtnf_pkg::ADDR_W-1:0]         station_address,
    input  wire logic signed [rtnf_pkg::LEVEL_W-1:0] signal_level,
    input  wire logic [rtnf_pkg::TIME_W-1:0]         scan_time,
    input  wire logic                                last_item,
    output logic                                     strobe,
    output logic [SLOT_W-1:0]                        slot_index,
    output logic [rtnf_pkg::HASH_W-1:0]              address_hash,
    output logic signed [rtnf_pkg::LEVEL_W-1:0]      slot_level,
    output logic [CNT_W-1:0]                         entry_count,
    output logic [rtnf_pkg::TIME_W-1:0]              stamp,
    output logic                                     final_slot
);

    import rtnf_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    // Front: take transactions into the command queue
    rtnf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .station_address (station_address),
        .signal_level    (signal_level),
        .scan_time       (scan_time),
        .last_item       (last_item),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    // Back: store entries, rank and emit slots
    rtnf_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TOP_N       (TOP_N)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .strobe       (strobe),
        .slot_index   (slot_index),
        .address_hash (address_hash),
        .slot_level   (slot_level),
        .entry_count  (entry_count),
        .stamp        (stamp),
        .final_slot   (final_slot)
    );

endmodule

`default_nettype wire
